// ----- src/rps_pkg.sv -----
// ----------------------------------------------------------------------------
// rps_pkg - shared types and constants for the rotated pattern sampler
// Item modes, configuration register indexes, sequencer states and the
// fixed-point widths of the coordinate transform.
// ----------------------------------------------------------------------------
package rps_pkg;

  // item modes
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_SAMPLE  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_TERM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_TERM  = 2'd2;
  localparam int unsigned CFG_DATA_W = 24;

  // field widths
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIXEL_W = 4 * CHAN_W;

  // transform datapath widths
  localparam int unsigned DX_W       = POS_W + SCALE_W + 1;  // offset * scale, Q.16
  localparam int unsigned PROD_W     = DX_W + TRIG_W;        // Q.30 products
  localparam int unsigned SUM_W      = PROD_W + 3;           // sum with centre and half
  localparam int unsigned FRAC_SHIFT = 30;
  localparam int unsigned HALF_SHIFT = FRAC_SHIFT - 1;
  localparam int unsigned COORD_W    = SUM_W - FRAC_SHIFT;   // rounded pixel coordinate

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFORM,
    ST_LOOK,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } coord_t;

endpackage

// ----- src/rps_if.sv -----
// ----------------------------------------------------------------------------
// rps_req_if / rps_rsp_if - item channels of the rotated pattern sampler
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rps_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic signed [rps_pkg::POS_W-1:0]   x_pos;
  logic signed [rps_pkg::POS_W-1:0]   y_pos;
  logic [rps_pkg::CHAN_W-1:0]         red_in;
  logic [rps_pkg::CHAN_W-1:0]         green_in;
  logic [rps_pkg::CHAN_W-1:0]         blue_in;
  logic [rps_pkg::CHAN_W-1:0]         matte_in;

  modport source (output valid, mode, x_pos, y_pos, red_in, green_in, blue_in, matte_in,
                  input ready);
  modport sink   (input valid, mode, x_pos, y_pos, red_in, green_in, blue_in, matte_in,
                  output ready);
endinterface

interface rps_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [rps_pkg::CHAN_W-1:0] red_out;
  logic [rps_pkg::CHAN_W-1:0] green_out;
  logic [rps_pkg::CHAN_W-1:0] blue_out;
  logic [rps_pkg::CHAN_W-1:0] matte_out;

  modport source (output valid, hit, red_out, green_out, blue_out, matte_out,
                  input ready);
  modport sink   (input valid, hit, red_out, green_out, blue_out, matte_out,
                  output ready);
endinterface

// ----- src/rps_xform.sv -----
// ----------------------------------------------------------------------------
// rps_xform - scale, rotate and round a sample offset to a pixel
// Three register stages: offset times inverse scale, the four rotation
// products, then sum with the box centre plus one half, floored to a pixel.
// ----------------------------------------------------------------------------
module rps_xform #(
  parameter int unsigned CW = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rps_pkg::POS_W-1:0]     x_pos,
  input  logic signed [rps_pkg::POS_W-1:0]     y_pos,
  input  logic [rps_pkg::SCALE_W-1:0]          inv_scale,
  input  logic signed [rps_pkg::TRIG_W-1:0]    cos_term,
  input  logic signed [rps_pkg::TRIG_W-1:0]    sin_term,
  input  logic [CW:0]                          cx_sum,
  input  logic [CW:0]                          cy_sum,
  output logic                                 done,
  output rps_pkg::coord_t                      coord
);

  logic                                 v1, v2, v3;
  logic signed [rps_pkg::DX_W-1:0]      dx, dy;
  logic signed [rps_pkg::PROD_W-1:0]    p_xc, p_ys, p_xs, p_yc;
  logic signed [rps_pkg::SUM_W-1:0]     u_sum, v_sum;
  logic signed [rps_pkg::SUM_W-1:0]     cen_x, cen_y, half;

  always_comb begin
    cen_x = $signed(rps_pkg::SUM_W'({cx_sum, rps_pkg::HALF_SHIFT'(0)}));
    cen_y = $signed(rps_pkg::SUM_W'({cy_sum, rps_pkg::HALF_SHIFT'(0)}));
    half  = $signed(rps_pkg::SUM_W'(1) << rps_pkg::HALF_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // each stage advances only with its item, so the result holds afterwards
  always_ff @(posedge clk) begin
    // offset times inverse scale
    if (start) begin
      dx <= x_pos * $signed({1'b0, inv_scale});
      dy <= y_pos * $signed({1'b0, inv_scale});
    end
    // rotation products
    if (v1) begin
      p_xc <= dx * cos_term;
      p_ys <= dy * sin_term;
      p_xs <= dx * sin_term;
      p_yc <= dy * cos_term;
    end
    // centre plus one half, so the floor below rounds half up
    if (v2) begin
      u_sum <= rps_pkg::SUM_W'(p_xc) - rps_pkg::SUM_W'(p_ys) + cen_x + half;
      v_sum <= rps_pkg::SUM_W'(p_xs) + rps_pkg::SUM_W'(p_yc) + cen_y + half;
    end
  end

  assign done     = v3;
  assign coord.px = u_sum[rps_pkg::SUM_W-1:rps_pkg::FRAC_SHIFT];
  assign coord.py = v_sum[rps_pkg::SUM_W-1:rps_pkg::FRAC_SHIFT];

endmodule

// ----- src/rotated_pattern_sampler.sv -----
// ----------------------------------------------------------------------------
// rotated_pattern_sampler - nearest-neighbor rotate/scale pattern lookup
// Pattern store with an opaque bounding box and a sample transform.
// ----------------------------------------------------------------------------
// Usage:
//   req carries items: load (write one RGBA pixel, grow the opaque box),
//   sample (signed offset from the box centre), restart (clear the box).
//   rsp carries one item per sample: hit plus the sampled RGBA, all zero
//   on a miss. Loads, restarts and unused modes give no rsp item.
//   wr_en/wr_index/wr_data write inv_scale, cos_term and sin_term; write
//   them only while the block is idle.
// Item flow:
//   Loads and restarts leave the sequencer idle; a load writes the store on
//   the accepting edge. A sample holds req.ready low from acceptance until
//   its rsp item is loaded: it passes the multiply/rotate pipeline, forms
//   the store address and takes the registered store read, then waits for
//   the output register to be free. No new item is taken in that time.
// Reset and stall:
//   Reset clears the box, loads the register defaults and drops any rsp
//   item; the store keeps no reset value and needs every pixel loaded
//   before sampling. A stalled rsp item holds in the output register; the
//   next sample waits before delivery until that register frees up.
// ----------------------------------------------------------------------------
module rotated_pattern_sampler #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [rps_pkg::CFG_IDX_W-1:0]         wr_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0]        wr_data,
  rps_req_if.sink                               req,
  rps_rsp_if.source                             rsp
);

  localparam int unsigned CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DEPTH = 2 ** (2 * CW);

  // configuration
  logic [rps_pkg::SCALE_W-1:0]        inv_scale;
  logic signed [rps_pkg::TRIG_W-1:0]  cos_term, sin_term;

  // opaque bounding box
  logic [CW-1:0] box_left, box_top, box_right, box_bottom;
  logic          box_nonempty;

  // sequencer
  rps_pkg::state_t state, state_next;
  logic            accept, load_ok, out_load;
  logic [CW-1:0]   ld_x, ld_y;

  // transform
  logic            xf_done;
  rps_pkg::coord_t xf_coord;
  logic            in_box;
  logic [2*CW-1:0] rd_addr;

  // store read
  logic [rps_pkg::PIXEL_W-1:0] mem [DEPTH];
  logic [rps_pkg::PIXEL_W-1:0] rdata;
  logic                        look_in_box;
  logic                        pix_hit;

  // output register
  logic                       out_valid;
  logic                       out_hit;
  logic [rps_pkg::PIXEL_W-1:0] out_pix;

  assign req.ready = (state == rps_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;

  // load coordinates must fall inside the store
  assign load_ok = !req.x_pos[rps_pkg::POS_W-1] && !req.y_pos[rps_pkg::POS_W-1] &&
                   (rps_pkg::POS_W'(req.x_pos) < rps_pkg::POS_W'(MAX_DIM)) &&
                   (rps_pkg::POS_W'(req.y_pos) < rps_pkg::POS_W'(MAX_DIM));
  assign ld_x = req.x_pos[CW-1:0];
  assign ld_y = req.y_pos[CW-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale <= rps_pkg::SCALE_W'(65536);
      cos_term  <= rps_pkg::TRIG_W'(16384);
      sin_term  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        rps_pkg::CFG_INV_SCALE: inv_scale <= wr_data;
        rps_pkg::CFG_COS_TERM:  cos_term  <= wr_data[rps_pkg::TRIG_W-1:0];
        rps_pkg::CFG_SIN_TERM:  sin_term  <= wr_data[rps_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // bounding box: grow on opaque loads, clear on restart
  always_ff @(posedge clk) begin
    if (rst) begin
      box_left     <= CW'(MAX_DIM - 1);
      box_top      <= CW'(MAX_DIM - 1);
      box_right    <= '0;
      box_bottom   <= '0;
      box_nonempty <= 1'b0;
    end else if (accept) begin
      if (req.mode == rps_pkg::MODE_RESTART) begin
        box_left     <= CW'(MAX_DIM - 1);
        box_top      <= CW'(MAX_DIM - 1);
        box_right    <= '0;
        box_bottom   <= '0;
        box_nonempty <= 1'b0;
      end else if (req.mode == rps_pkg::MODE_LOAD && load_ok && req.matte_in != '0) begin
        if (ld_x < box_left)   box_left   <= ld_x;
        if (ld_x > box_right)  box_right  <= ld_x;
        if (ld_y < box_top)    box_top    <= ld_y;
        if (ld_y > box_bottom) box_bottom <= ld_y;
        box_nonempty <= 1'b1;
      end
    end
  end

  // scale and rotate the offset around the box centre
  rps_xform #(
    .CW (CW)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && req.mode == rps_pkg::MODE_SAMPLE),
    .x_pos     (req.x_pos),
    .y_pos     (req.y_pos),
    .inv_scale (inv_scale),
    .cos_term  (cos_term),
    .sin_term  (sin_term),
    .cx_sum    ((CW+1)'(box_left) + (CW+1)'(box_right)),
    .cy_sum    ((CW+1)'(box_top) + (CW+1)'(box_bottom)),
    .done      (xf_done),
    .coord     (xf_coord)
  );

  // box test on the rounded pixel; the box already lies inside the store
  assign in_box = box_nonempty &&
                  (xf_coord.px >= $signed(rps_pkg::COORD_W'(box_left))) &&
                  (xf_coord.px <= $signed(rps_pkg::COORD_W'(box_right))) &&
                  (xf_coord.py >= $signed(rps_pkg::COORD_W'(box_top))) &&
                  (xf_coord.py <= $signed(rps_pkg::COORD_W'(box_bottom)));
  assign rd_addr = {xf_coord.py[CW-1:0], xf_coord.px[CW-1:0]};

  // pattern store: one write port for loads, one registered read for samples
  always_ff @(posedge clk) begin
    if (accept && req.mode == rps_pkg::MODE_LOAD && load_ok) begin
      mem[{ld_y, ld_x}] <= {req.matte_in, req.blue_in, req.green_in, req.red_in};
    end
    if (state == rps_pkg::ST_LOOK) begin
      rdata       <= mem[rd_addr];
      look_in_box <= in_box;
    end
  end

  assign pix_hit = look_in_box && (rdata[rps_pkg::PIXEL_W-1 -: rps_pkg::CHAN_W] != '0);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      rps_pkg::ST_IDLE: begin
        if (accept && req.mode == rps_pkg::MODE_SAMPLE) state_next = rps_pkg::ST_XFORM;
      end
      rps_pkg::ST_XFORM: begin
        if (xf_done) state_next = rps_pkg::ST_LOOK;
      end
      rps_pkg::ST_LOOK: begin
        state_next = rps_pkg::ST_DELIVER;
      end
      rps_pkg::ST_DELIVER: begin
        // hold until the output register is free
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = rps_pkg::ST_IDLE;
        end
      end
      default: state_next = rps_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit <= pix_hit;
      out_pix <= pix_hit ? rdata : '0;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_hit;
  assign rsp.red_out   = out_pix[rps_pkg::CHAN_W-1:0];
  assign rsp.green_out = out_pix[2*rps_pkg::CHAN_W-1:rps_pkg::CHAN_W];
  assign rsp.blue_out  = out_pix[3*rps_pkg::CHAN_W-1:2*rps_pkg::CHAN_W];
  assign rsp.matte_out = out_pix[4*rps_pkg::CHAN_W-1:3*rps_pkg::CHAN_W];

endmodule

// ----- src/rps_check.sv -----
// ----------------------------------------------------------------------------
// rps_check - port-level checks for the rotated pattern sampler
// Watches the item channels and flags misbehavior over time.
// ----------------------------------------------------------------------------
module rps_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [1:0]                 req_mode,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_hit,
  input logic [rps_pkg::CHAN_W-1:0] rsp_red,
  input logic [rps_pkg::CHAN_W-1:0] rsp_green,
  input logic [rps_pkg::CHAN_W-1:0] rsp_blue,
  input logic [rps_pkg::CHAN_W-1:0] rsp_matte
);

  // reset drops any pending result item
  a_reset_drops: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  // a miss carries an all-zero pixel
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_hit) |->
      (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 && rsp_matte == '0))
    else $error("miss with nonzero pixel");

  // a hit is always an opaque pixel
  a_hit_opaque: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_hit) |-> (rsp_matte != '0))
    else $error("hit on transparent pixel");

  // a sample keeps the input side busy while it is worked on
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_mode == rps_pkg::MODE_SAMPLE) |=> !req_ready)
    else $error("input ready right after a sample");

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_hit) && $stable(rsp_red) && $stable(rsp_green) &&
       $stable(rsp_blue) && $stable(rsp_matte)))
    else $error("stalled rsp item changed");

endmodule

bind rotated_pattern_sampler rps_check u_rps_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_mode  (req.mode),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_hit   (rsp.hit),
  .rsp_red   (rsp.red_out),
  .rsp_green (rsp.green_out),
  .rsp_blue  (rsp.blue_out),
  .rsp_matte (rsp.matte_out)
);

// ----- bench/tb_rotated_pattern_sampler.sv -----
// ----------------------------------------------------------------------------
// tb_rotated_pattern_sampler - self-checking bench for the pattern sampler
// Drives load, sample, restart and unused items with random gaps on both
// channels. Each accepted item updates a bit-exact shadow of the pattern
// store and the opaque box; register writes update the shadow registers. Every sample
// item queues the pixel it should return, and every rsp item is checked
// against the oldest one.
// ----------------------------------------------------------------------------
module tb_rotated_pattern_sampler;

  localparam int          CYCLE          = 20;
  localparam int          TIMEOUT_CYCLES = 400000;
  localparam int          PAT_DIM        = 256;
  localparam int          RANDOM_ITEMS   = 850;
  localparam int          MAX_GAP        = 13;
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam longint      HALF_Q30       = 64'sd536870912;

  typedef struct packed {
    logic [1:0]                       mode;
    logic signed [rps_pkg::POS_W-1:0] x_pos;
    logic signed [rps_pkg::POS_W-1:0] y_pos;
    logic [rps_pkg::CHAN_W-1:0]       red;
    logic [rps_pkg::CHAN_W-1:0]       green;
    logic [rps_pkg::CHAN_W-1:0]       blue;
    logic [rps_pkg::CHAN_W-1:0]       matte;
  } req_item_t;

  typedef struct packed {
    logic                       hit;
    logic [rps_pkg::CHAN_W-1:0] red;
    logic [rps_pkg::CHAN_W-1:0] green;
    logic [rps_pkg::CHAN_W-1:0] blue;
    logic [rps_pkg::CHAN_W-1:0] matte;
  } pixel_result_t;

  logic                           clk;
  logic                           rst;
  logic                           wr_en;
  logic [rps_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [rps_pkg::CFG_DATA_W-1:0] wr_data;

  rps_req_if req_ch ();
  rps_rsp_if rsp_ch ();

  rotated_pattern_sampler uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // stimulus and expectations
  req_item_t     pending_items[$];
  pixel_result_t expected_pixels[$];
  req_item_t     on_bus;

  // shadow of the block: store, opaque box and registers
  logic [rps_pkg::PIXEL_W-1:0] pattern_copy [0:PAT_DIM*PAT_DIM-1];
  longint box_l, box_t, box_r, box_b;
  bit     box_opaque;
  longint cfg_scale, cfg_cos, cfg_sin;

  // run statistics
  int mismatches;
  int accepted_items;
  int counted_items;
  int samples_checked;
  int hits_seen;
  int settings_used;

  // handshake pacing
  int unsigned req_wait;
  int unsigned rsp_wait;
  bit          req_burst;
  bit          rsp_burst;

  pixel_result_t want_pix;
  pixel_result_t got_pix;

  // --------------------------------------------------------------------------
  // clock, and known values on every input from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = rps_pkg::MODE_LOAD;
    req_ch.x_pos = '0;
    req_ch.y_pos = '0;
    req_ch.red_in = '0;
    req_ch.green_in = '0;
    req_ch.blue_in = '0;
    req_ch.matte_in = '0;
    rsp_ch.ready = 1'b0;
    forever #(CYCLE / 2) clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(CYCLE * TIMEOUT_CYCLES);
    $display("timeout after %0d cycles, %0d results still pending", TIMEOUT_CYCLES,
             expected_pixels.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // reporting
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_mismatch($sformatf("sample %0d %s got %0d want %0d", samples_checked, name,
                              got, want));
  endtask

  // --------------------------------------------------------------------------
  // predictor: apply one accepted item to the shadow, queue any result
  // --------------------------------------------------------------------------
  task automatic clear_box();
    box_l = PAT_DIM - 1;
    box_t = PAT_DIM - 1;
    box_r = 0;
    box_b = 0;
    box_opaque = 1'b0;
  endtask

  task automatic predict_lookup(input req_item_t it);
    longint        xo, yo, dx, dy, px, py;
    logic [rps_pkg::PIXEL_W-1:0] pix;
    pixel_result_t res;
    xo = longint'($signed(it.x_pos));
    yo = longint'($signed(it.y_pos));
    case (it.mode)
      rps_pkg::MODE_LOAD: begin
        // drop loads outside the store entirely
        if (xo >= 0 && xo < PAT_DIM && yo >= 0 && yo < PAT_DIM) begin
          pattern_copy[int'(yo * PAT_DIM + xo)] = {it.matte, it.blue, it.green, it.red};
          // only opaque pixels widen the box; it never shrinks here
          if (it.matte != '0) begin
            if (xo < box_l) box_l = xo;
            if (xo > box_r) box_r = xo;
            if (yo < box_t) box_t = yo;
            if (yo > box_b) box_b = yo;
            box_opaque = 1'b1;
          end
        end
      end
      rps_pkg::MODE_RESTART: clear_box();
      rps_pkg::MODE_SAMPLE: begin
        // scale to Q.16, rotate to Q.30, add the box centre (half pixels
        // are exact at Q.29), then round half up by flooring after +0.5
        dx = xo * cfg_scale;
        dy = yo * cfg_scale;
        px = (dx * cfg_cos - dy * cfg_sin + (box_l + box_r) * (64'sd1 <<< 29) + HALF_Q30)
             >>> 30;
        py = (dx * cfg_sin + dy * cfg_cos + (box_t + box_b) * (64'sd1 <<< 29) + HALF_Q30)
             >>> 30;
        res = '0;
        if (box_opaque && px >= box_l && px <= box_r && py >= box_t && py <= box_b) begin
          pix = pattern_copy[int'(py * PAT_DIM + px)];
          if (pix[31:24] != '0) begin
            res.hit   = 1'b1;
            res.red   = pix[7:0];
            res.green = pix[15:8];
            res.blue  = pix[23:16];
            res.matte = pix[31:24];
          end
        end
        expected_pixels.push_back(res);
      end
      default: ;  // unused mode: no effect, no result
    endcase
  endtask

  function automatic int unsigned pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // --------------------------------------------------------------------------
  // driver: present pending items, predict each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_wait = pick_gap(1'b0);
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_lookup(on_bus);
        accepted_items++;
      end
      // the slot is free when nothing is shown or the shown item just moved
      if (!req_ch.valid || req_ch.ready) begin
        if (req_wait > 0) begin
          req_wait--;
          req_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_bus = pending_items.pop_front();
          req_ch.mode     <= on_bus.mode;
          req_ch.x_pos    <= on_bus.x_pos;
          req_ch.y_pos    <= on_bus.y_pos;
          req_ch.red_in   <= on_bus.red;
          req_ch.green_in <= on_bus.green;
          req_ch.blue_in  <= on_bus.blue;
          req_ch.matte_in <= on_bus.matte;
          req_ch.valid    <= 1'b1;
          // switch now and then between back-to-back and gapped items
          if ($urandom_range(0, 39) == 0) req_burst = ~req_burst;
          req_wait = pick_gap(req_burst);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: stall rsp at random, check each item against the oldest one due
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got_pix.hit   = rsp_ch.hit;
        got_pix.red   = rsp_ch.red_out;
        got_pix.green = rsp_ch.green_out;
        got_pix.blue  = rsp_ch.blue_out;
        got_pix.matte = rsp_ch.matte_out;
        if (expected_pixels.size() == 0) begin
          flag_mismatch("rsp item with no sample pending");
        end else begin
          want_pix = expected_pixels.pop_front();
          check_field("hit", got_pix.hit, want_pix.hit);
          check_field("red", got_pix.red, want_pix.red);
          check_field("green", got_pix.green, want_pix.green);
          check_field("blue", got_pix.blue, want_pix.blue);
          check_field("matte", got_pix.matte, want_pix.matte);
          if (want_pix.hit) hits_seen++;
        end
        samples_checked++;
        if ($urandom_range(0, 39) == 0) rsp_burst = ~rsp_burst;
        rsp_wait = pick_gap(rsp_burst);
      end
      if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] mode, input int x, input int y,
                           input int r, input int g, input int b, input int m);
    req_item_t it;
    it.mode  = mode;
    it.x_pos = rps_pkg::POS_W'(x);
    it.y_pos = rps_pkg::POS_W'(y);
    it.red   = rps_pkg::CHAN_W'(r);
    it.green = rps_pkg::CHAN_W'(g);
    it.blue  = rps_pkg::CHAN_W'(b);
    it.matte = rps_pkg::CHAN_W'(m);
    pending_items.push_back(it);
    // ignored items do not count toward the run length
    if (mode == MODE_UNUSED) return;
    if (mode == rps_pkg::MODE_LOAD &&
        ($signed(it.x_pos) < 0 || $signed(it.x_pos) >= PAT_DIM ||
         $signed(it.y_pos) < 0 || $signed(it.y_pos) >= PAT_DIM))
      return;
    counted_items++;
  endtask

  // hold off until the block has drained, then let the pipeline go quiet
  task automatic settle();
    while (pending_items.size() != 0 || req_ch.valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // write one register and track it in the shadow
  task automatic write_reg(input logic [rps_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= rps_pkg::CFG_DATA_W'(value);
    case (idx)
      rps_pkg::CFG_INV_SCALE: cfg_scale = longint'(value) & 64'hFFFFFF;
      rps_pkg::CFG_COS_TERM:  cfg_cos   = longint'($signed(rps_pkg::TRIG_W'(value)));
      rps_pkg::CFG_SIN_TERM:  cfg_sin   = longint'($signed(rps_pkg::TRIG_W'(value)));
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic load_pixel(input int x, input int y, input int clear_pct);
    int m;
    m = ($urandom_range(0, 99) < clear_pct) ? 0 : $urandom_range(1, 255);
    push_item(rps_pkg::MODE_LOAD, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), m);
  endtask

  // load the first count pixels of a rectangle in raster order
  task automatic load_rect(input int x0, input int y0, input int w, input int h,
                           input int count, input int clear_pct);
    for (int i = 0; i < count; i++)
      load_pixel(x0 + i % w, y0 + i / w, clear_pct);
  endtask

  // mostly offsets that land near the box, some anywhere, some at the limits
  function automatic int pick_offset(input int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return int'($signed(rps_pkg::POS_W'($urandom)));
    if (sel == 1) return $urandom_range(0, 1) ? -32768 : 32767;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  int rx, ry, rw, rh, clear_pct, span, n_samples, sel, oob_x, oob_y;
  int set_scale, set_cos, set_sin;
  longint span_l;

  initial begin
    clear_box();
    cfg_scale = 65536;
    cfg_cos = 16384;
    cfg_sin = 0;
    mismatches = 0;
    req_burst = 1'b0;
    rsp_burst = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset settings
    push_item(rps_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0, 0);                 // empty box
    push_item(MODE_UNUSED, 5, 5, 255, 255, 255, 255);                  // unused mode
    push_item(rps_pkg::MODE_LOAD, -32768, 32767, 255, 255, 255, 255);  // off the store
    push_item(rps_pkg::MODE_LOAD, 256, 0, 255, 255, 255, 255);
    push_item(rps_pkg::MODE_LOAD, 0, -1, 255, 255, 255, 255);
    // 2x2 at the far corner, one pixel transparent
    push_item(rps_pkg::MODE_LOAD, 254, 254, 0, 0, 0, 255);
    push_item(rps_pkg::MODE_LOAD, 255, 254, 255, 255, 255, 1);
    push_item(rps_pkg::MODE_LOAD, 254, 255, 17, 34, 51, 0);
    push_item(rps_pkg::MODE_LOAD, 255, 255, 255, 0, 255, 128);
    push_item(rps_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0, 0);           // centre rounds half up
    push_item(rps_pkg::MODE_SAMPLE, -1, -1, 0, 0, 0, 0);
    push_item(rps_pkg::MODE_SAMPLE, -1, 0, 0, 0, 0, 0);          // transparent pixel
    push_item(rps_pkg::MODE_SAMPLE, 1, 1, 0, 0, 0, 0);           // just past the box
    push_item(rps_pkg::MODE_SAMPLE, -32768, 32767, 0, 0, 0, 0);
    push_item(rps_pkg::MODE_SAMPLE, 32767, -32768, 0, 0, 0, 0);
    push_item(rps_pkg::MODE_RESTART, 0, 0, 0, 0, 0, 0);
    push_item(rps_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0, 0);           // box cleared, store kept
    push_item(rps_pkg::MODE_LOAD, 0, 0, 9, 9, 9, 0);             // transparent: box empty
    push_item(rps_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0, 0);
    push_item(rps_pkg::MODE_LOAD, 255, 255, 1, 2, 3, 4);         // single opaque pixel
    push_item(rps_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0, 0);
    push_item(rps_pkg::MODE_SAMPLE, 0, -1, 0, 0, 0, 0);
    settle();

    counted_items = 0;
    settings_used = 1;
    while (counted_items < RANDOM_ITEMS) begin
      settle();

      // register setting: the extremes first, then random mixes
      case (settings_used)
        1: begin set_scale = 0;        set_cos = -16384; set_sin = 0;      end
        2: begin set_scale = 24'hFFFFFF; set_cos = 0;    set_sin = 16384;  end
        3: begin set_scale = 65536;    set_cos = 16384;  set_sin = -16384; end
        4: begin set_scale = 32768;    set_cos = 11585;  set_sin = -11585; end
        default: begin
          case ($urandom_range(0, 6))
            0: set_scale = 65536;
            1: set_scale = 0;
            2: set_scale = 24'hFFFFFF;
            3: set_scale = $urandom_range(16384, 262144);
            4: set_scale = $urandom_range(0, 24'hFFFFFF);
            5: set_scale = 32768;
            default: set_scale = 131072;
          endcase
          case ($urandom_range(0, 5))
            0: begin set_cos = 16384;  set_sin = 0;      end
            1: begin set_cos = 0;      set_sin = 16384;  end
            2: begin set_cos = -16384; set_sin = 0;      end
            3: begin set_cos = 0;      set_sin = -16384; end
            4: begin
              set_cos = int'($urandom_range(0, 32768)) - 16384;
              set_sin = int'($urandom_range(0, 32768)) - 16384;
            end
            default: begin
              set_cos = $urandom_range(0, 1) ? 11585 : -11585;
              set_sin = $urandom_range(0, 1) ? 11585 : -11585;
            end
          endcase
        end
      endcase
      write_reg(rps_pkg::CFG_INV_SCALE, set_scale);
      write_reg(rps_pkg::CFG_COS_TERM, set_cos);
      write_reg(rps_pkg::CFG_SIN_TERM, set_sin);
      settings_used++;

      // pattern rectangle: mostly small, sometimes against the store limits
      if ($urandom_range(0, 7) == 0) begin
        rw = $urandom_range(1, 16);
        rh = $urandom_range(1, 16);
      end else begin
        rw = $urandom_range(1, 8);
        rh = $urandom_range(1, 8);
      end
      case ($urandom_range(0, 7))
        0: rx = 0;
        1: rx = PAT_DIM - rw;
        default: rx = $urandom_range(0, PAT_DIM - rw);
      endcase
      case ($urandom_range(0, 7))
        0: ry = 0;
        1: ry = PAT_DIM - rh;
        default: ry = $urandom_range(0, PAT_DIM - rh);
      endcase
      clear_pct = $urandom_range(0, 50);

      push_item(rps_pkg::MODE_RESTART, 0, 0, 0, 0, 0, 0);
      // broken sequence: abandon a partial load and start over
      if (rw * rh > 1 && $urandom_range(0, 4) == 0) begin
        load_rect(rx, ry, rw, rh, $urandom_range(1, rw * rh - 1), clear_pct);
        push_item(rps_pkg::MODE_RESTART, 0, 0, 0, 0, 0, 0);
      end
      // sampling only starts once the whole rectangle is written, so the
      // opaque box never covers a pixel that was not loaded
      load_rect(rx, ry, rw, rh, rw * rh, clear_pct);

      // offsets that map back to about the rectangle at this scale
      span_l = (longint'((rw > rh ? rw : rh) + 2) * 65536) / (longint'(set_scale) + 1);
      span = (span_l > 16000) ? 16000 : ((span_l < 1) ? 1 : int'(span_l));

      n_samples = $urandom_range(8, 30);
      for (int i = 0; i < n_samples; i++) begin
        sel = $urandom_range(0, 19);
        case (sel)
          0: push_item(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
          1: begin
            // a load at least one coordinate of which is off the store
            oob_x = int'($signed(rps_pkg::POS_W'($urandom)));
            oob_y = int'($signed(rps_pkg::POS_W'($urandom)));
            while (oob_x >= 0 && oob_x < PAT_DIM && oob_y >= 0 && oob_y < PAT_DIM)
              oob_x = int'($signed(rps_pkg::POS_W'($urandom)));
            load_pixel(oob_x, oob_y, 0);
          end
          2: load_pixel($urandom_range(0, PAT_DIM - 1), $urandom_range(0, PAT_DIM - 1), 100);
          3: load_pixel(rx + $urandom_range(0, rw - 1), ry + $urandom_range(0, rh - 1),
                        clear_pct);
          4: begin
            // restart mid-stream, miss once, then reload the rectangle
            push_item(rps_pkg::MODE_RESTART, 0, 0, 0, 0, 0, 0);
            push_item(rps_pkg::MODE_SAMPLE, pick_offset(span), pick_offset(span),
                      0, 0, 0, 0);
            load_rect(rx, ry, rw, rh, rw * rh, clear_pct);
          end
          default: push_item(rps_pkg::MODE_SAMPLE, pick_offset(span), pick_offset(span),
                             $urandom, $urandom, $urandom, $urandom);
        endcase
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0)
      flag_mismatch($sformatf("%0d samples never answered", expected_pixels.size()));
    $display("run: %0d items accepted under %0d register settings", accepted_items,
             settings_used);
    $display("run: %0d samples checked, %0d of them hits, %0d mismatches", samples_checked,
             hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- rotated_pattern_sampler.f -----
src/rps_pkg.sv
src/rps_if.sv
src/rps_xform.sv
src/rotated_pattern_sampler.sv
src/rps_check.sv
bench/tb_rotated_pattern_sampler.sv
